### rtl/core/psfs_pkg.sv
// psfs_pkg: shared widths, register codes, constants and word types of the
// point source field sampler; no dependencies
`default_nettype none

package psfs_pkg;

    // field and register widths
    localparam int IDX_W  = 12;
    localparam int WL_W   = 24;
    localparam int DIST_W = 44;
    localparam int LEN_W  = 31;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIST_W;

    // datapath widths, all in half picometres
    localparam int ISP_W  = IDX_W + LEN_W;        // idx * spacing
    localparam int Y_W    = ISP_W + 4;            // signed lateral position
    localparam int MAG_W  = 45;                   // |y|
    localparam int Z_W    = DIST_W + 1;           // 2 * distance
    localparam int SQ_W   = 2 * MAG_W;            // y^2, z^2
    localparam int V_W    = SQ_W + 3;             // sqrt operand
    localparam int SQRT_STEPS = (V_W + 1) / 2;
    localparam int D_W    = Z_W + 2;              // sqrt + z
    localparam int DEN_W  = D_W + WL_W;
    localparam int NUM_W  = SQ_W + 25;            // y^2 * 32768000
    localparam int DIV_STEPS = NUM_W;

    localparam int PH_W   = 16;
    localparam int Q15_W  = 16;

    // 2*pi in q32, angle of one lsb of the quarter turn is scaled by 2^-18
    localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVELENGTH = 3'd0,
        REG_DISTANCE   = 3'd1,
        REG_APERTURE   = 3'd2,
        REG_SPACING    = 3'd3,
        REG_OFFSET     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [WL_W-1:0]          wavelength;
        logic [DIST_W-1:0]        distance;
        logic [LEN_W-1:0]         aperture;
        logic [LEN_W-1:0]         spacing;
        logic signed [LEN_W-1:0]  offset;
    } cfg_t;

    // geometry to square root
    typedef struct packed {
        logic [V_W-1:0]  v;
        logic [SQ_W-1:0] ysq;
    } sq_t;

    // square root to divider
    typedef struct packed {
        logic [D_W-1:0]  d;
        logic [SQ_W-1:0] ysq;
    } rt_t;

    // finished result word
    typedef struct packed {
        logic [Q15_W-1:0] imag_part;
        logic [Q15_W-1:0] real_part;
        logic [PH_W-1:0]  phase_turns;
    } res_t;

endpackage

`default_nettype wire

### rtl/core/psfs_geom.sv
// psfs_geom: lateral position, squares of position and distance and their sum
// depends on psfs_pkg
`default_nettype none

module psfs_geom
    import psfs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [IDX_W-1:0]  in_idx,
    input  wire cfg_t              cfg,
    output logic                   out_valid,
    output sq_t                    out_word
);

    localparam int LO_W = 23;
    localparam int YH_W = MAG_W - LO_W;
    localparam int ZH_W = Z_W - LO_W;

    logic [4:0]              vld_reg;
    logic [ISP_W-1:0]        isp_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [2*LO_W-1:0]       yll_reg, zll_reg;
    logic [LO_W+YH_W-1:0]    ylh_reg;
    logic [LO_W+ZH_W-1:0]    zlh_reg;
    logic [2*YH_W-1:0]       yhh_reg;
    logic [2*ZH_W-1:0]       zhh_reg;
    logic [SQ_W-1:0]         ysq_reg, zsq_reg, ysq2_reg;
    logic [V_W-1:0]          v_reg;

    logic signed [Y_W-1:0]   y_next;
    logic [MAG_W-1:0]        mag_next;
    logic [Z_W-1:0]          z;

    assign z = {cfg.distance, 1'b0};

    // y = 2*idx*spacing + 2*offset - aperture
    assign y_next = $signed({3'b000, isp_reg, 1'b0})
                  + $signed({{(Y_W-LEN_W-1){cfg.offset[LEN_W-1]}}, cfg.offset, 1'b0})
                  - $signed({{(Y_W-LEN_W){1'b0}}, cfg.aperture});
    assign mag_next = y_next[Y_W-1] ? MAG_W'(-y_next) : MAG_W'(y_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            isp_reg <= ISP_W'(in_idx) * ISP_W'(cfg.spacing);
            mag_reg <= mag_next;
            // split squares into narrow partial products
            yll_reg <= (2*LO_W)'(mag_reg[LO_W-1:0]) * (2*LO_W)'(mag_reg[LO_W-1:0]);
            ylh_reg <= (LO_W+YH_W)'(mag_reg[LO_W-1:0]) * (LO_W+YH_W)'(mag_reg[MAG_W-1:LO_W]);
            yhh_reg <= (2*YH_W)'(mag_reg[MAG_W-1:LO_W]) * (2*YH_W)'(mag_reg[MAG_W-1:LO_W]);
            zll_reg <= (2*LO_W)'(z[LO_W-1:0]) * (2*LO_W)'(z[LO_W-1:0]);
            zlh_reg <= (LO_W+ZH_W)'(z[LO_W-1:0]) * (LO_W+ZH_W)'(z[Z_W-1:LO_W]);
            zhh_reg <= (2*ZH_W)'(z[Z_W-1:LO_W]) * (2*ZH_W)'(z[Z_W-1:LO_W]);
            ysq_reg <= SQ_W'(yll_reg) + (SQ_W'(ylh_reg) << (LO_W+1))
                     + (SQ_W'(yhh_reg) << (2*LO_W));
            zsq_reg <= SQ_W'(zll_reg) + (SQ_W'(zlh_reg) << (LO_W+1))
                     + (SQ_W'(zhh_reg) << (2*LO_W));
            v_reg    <= V_W'(ysq_reg) + V_W'(zsq_reg);
            ysq2_reg <= ysq_reg;
        end
    end

    assign out_valid    = vld_reg[4];
    assign out_word.v   = v_reg;
    assign out_word.ysq = ysq2_reg;

endmodule

`default_nettype wire

### rtl/core/psfs_sqrt.sv
// psfs_sqrt: pipelined integer square root, one result bit per stage, plus z
// depends on psfs_pkg
`default_nettype none

module psfs_sqrt
    import psfs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire sq_t               in_word,
    input  wire logic [DIST_W-1:0] distance,
    output logic                   out_valid,
    output rt_t                    out_word
);

    logic [V_W-1:0]    v_reg   [SQRT_STEPS];
    logic [V_W-1:0]    res_reg [SQRT_STEPS];
    logic [SQ_W-1:0]   ysq_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] vld_reg;
    logic              dvld_reg;
    logic [D_W-1:0]    d_reg;
    logic [SQ_W-1:0]   dysq_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [V_W-1:0] BIT = V_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [V_W-1:0]  v_in, r_in, t;
        logic [SQ_W-1:0] ysq_in;
        logic            vld_in;

        if (k == 0) begin : g_first
            assign v_in   = in_word.v;
            assign r_in   = '0;
            assign ysq_in = in_word.ysq;
            assign vld_in = in_valid;
        end else begin : g_next
            assign v_in   = v_reg[k-1];
            assign r_in   = res_reg[k-1];
            assign ysq_in = ysq_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        assign t = r_in + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ysq_reg[k] <= ysq_in;
                if (v_in >= t) begin
                    v_reg[k]   <= v_in - t;
                    res_reg[k] <= (r_in >> 1) + BIT;
                end else begin
                    v_reg[k]   <= v_in;
                    res_reg[k] <= r_in >> 1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvld_reg <= 1'b0;
        end else if (en) begin
            dvld_reg <= vld_reg[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= D_W'(res_reg[SQRT_STEPS-1]) + D_W'({distance, 1'b0});
            dysq_reg <= ysq_reg[SQRT_STEPS-1];
        end
    end

    assign out_valid    = dvld_reg;
    assign out_word.d   = d_reg;
    assign out_word.ysq = dysq_reg;

endmodule

`default_nettype wire

### rtl/core/psfs_div.sv
// psfs_div: forms numerator and denominator and runs a restoring divider,
// one quotient bit per stage, keeping the low phase bits; depends on psfs_pkg
`default_nettype none

module psfs_div
    import psfs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire rt_t               in_word,
    input  wire logic [WL_W-1:0]   wavelength,
    output logic                   out_valid,
    output logic [PH_W-1:0]        out_phase
);

    localparam int DL_W = 24;
    localparam int DH_W = D_W - DL_W;
    localparam int REM_W = DEN_W;

    logic                  a_vld_reg, b_vld_reg, p_vld_reg;
    logic [DL_W+WL_W-1:0]  plo_reg;
    logic [DH_W+WL_W-1:0]  phi_reg;
    logic [NUM_W-1:0]      a_num_reg, b_num_reg;
    logic                  a_zero_reg, b_zero_reg;
    logic [DEN_W-1:0]      b_den_reg;
    logic [NUM_W-1:0]      ysq_w;

    logic [NUM_W-1:0]  num_reg  [DIV_STEPS];
    logic [REM_W-1:0]  rem_reg  [DIV_STEPS];
    logic [DEN_W-1:0]  den_reg  [DIV_STEPS];
    logic [PH_W-1:0]   q_reg    [DIV_STEPS];
    logic              zero_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;
    logic [PH_W-1:0]   phase_reg;

    assign ysq_w = NUM_W'(in_word.ysq);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            p_vld_reg <= vld_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg    <= (DL_W+WL_W)'(in_word.d[DL_W-1:0]) * (DL_W+WL_W)'(wavelength);
            phi_reg    <= (DH_W+WL_W)'(in_word.d[D_W-1:DL_W]) * (DH_W+WL_W)'(wavelength);
            // 32768000 = 2^25 - 2^19 - 2^18
            a_num_reg  <= (ysq_w << 25) - (ysq_w << 19) - (ysq_w << 18);
            a_zero_reg <= (in_word.d == '0) || (wavelength == '0);
            b_den_reg  <= DEN_W'(plo_reg) + (DEN_W'(phi_reg) << DL_W);
            b_num_reg  <= a_num_reg;
            b_zero_reg <= a_zero_reg;
            phase_reg  <= zero_reg[DIV_STEPS-1] ? '0 : q_reg[DIV_STEPS-1];
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [NUM_W-1:0] num_in;
        logic [REM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [PH_W-1:0]  q_in;
        logic             zero_in, vld_in;
        logic [REM_W:0]   rs;

        if (k == 0) begin : g_first
            assign num_in  = b_num_reg;
            assign rem_in  = '0;
            assign den_in  = b_den_reg;
            assign q_in    = '0;
            assign zero_in = b_zero_reg;
            assign vld_in  = b_vld_reg;
        end else begin : g_next
            assign num_in  = num_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign zero_in = zero_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign rs = {rem_in, num_in[NUM_W-1]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k]  <= num_in << 1;
                den_reg[k]  <= den_in;
                zero_reg[k] <= zero_in;
                if (rs >= {1'b0, den_in}) begin
                    rem_reg[k] <= REM_W'(rs - {1'b0, den_in});
                    q_reg[k]   <= {q_in[PH_W-2:0], 1'b1};
                end else begin
                    rem_reg[k] <= REM_W'(rs);
                    q_reg[k]   <= {q_in[PH_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = p_vld_reg;
    assign out_phase = phase_reg;

endmodule

`default_nettype wire

### rtl/core/psfs_trig.sv
// psfs_trig: pipelined taylor sine and cosine of the phase in q1.15
// depends on psfs_pkg
`default_nettype none

module psfs_trig
    import psfs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [PH_W-1:0]  in_phase,
    output logic                  out_valid,
    output res_t                  out_word
);

    localparam int ROUNDS = 6;
    localparam int SIN_ROUNDS = 5;
    localparam int TH_W = 31;
    localparam int T_W  = 32;
    localparam int S_W  = 34;
    localparam int unsigned SIN_DIV [SIN_ROUNDS] = '{6, 20, 42, 72, 110};
    localparam int unsigned COS_DIV [ROUNDS]     = '{2, 12, 30, 56, 90, 132};

    typedef struct packed {
        logic [PH_W-1:0]       phase;
        logic [T_W-1:0]        t2;
        logic [T_W-1:0]        s_term;
        logic [T_W-1:0]        c_term;
        logic [T_W-1:0]        s_x;
        logic [T_W-1:0]        c_x;
        logic [T_W-1:0]        s_qe;
        logic [T_W-1:0]        c_qe;
        logic signed [S_W-1:0] s_sum;
        logic signed [S_W-1:0] c_sum;
    } trig_t;

    function automatic logic [Q15_W-1:0] to_q15(input logic signed [S_W-1:0] s);
        logic [S_W-1:0] p;
        logic [S_W-1:0] v;
        p = s[S_W-1] ? '0 : S_W'(s);
        v = (p + S_W'(16384)) >> 15;
        return (v > S_W'(32767)) ? Q15_W'(32767) : Q15_W'(v);
    endfunction

    logic            v0_reg, v1_reg, vf_reg;
    logic [PH_W-1:0] ph0_reg, ph1_reg;
    logic [TH_W-1:0] th0_reg, th1_reg;
    logic [T_W-1:0]  t2_reg;
    logic [48:0]     th_prod;
    logic [2*TH_W-1:0] t2_prod;

    trig_t           st_reg  [3*ROUNDS];
    logic [3*ROUNDS-1:0] vld_reg;
    res_t            res_reg;

    // angle in q30 radians from the low phase bits
    assign th_prod = 49'(in_phase[PH_W-3:0]) * 49'(TWO_PI_Q32) + 49'(1 << 17);
    assign t2_prod = (2*TH_W)'(th0_reg) * (2*TH_W)'(th0_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            vf_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            vf_reg <= vld_reg[3*ROUNDS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            th0_reg <= TH_W'(th_prod >> 18);
            ph0_reg <= in_phase;
            th1_reg <= th0_reg;
            ph1_reg <= ph0_reg;
            t2_reg  <= t2_prod[2*TH_W-1:30];
        end
    end

    for (genvar k = 0; k < ROUNDS; k++) begin : g_round
        localparam int unsigned CC = COS_DIV[k];
        localparam int unsigned SC = (k < SIN_ROUNDS) ? SIN_DIV[(k < SIN_ROUNDS) ? k : 0] : 1;
        localparam logic [T_W-1:0] C_RECIP = T_W'((64'd1 << 32) / 64'(CC));
        localparam logic [T_W-1:0] S_RECIP = T_W'((64'd1 << 32) / 64'(SC));
        localparam bit NEG = (k % 2) == 0;

        trig_t a_in, a_nx, b_nx, c_nx;
        logic  vld_in;
        logic [2*T_W-1:0] s_p, c_p, s_e, c_e;
        logic [T_W+7:0]   s_r, c_r;
        logic [T_W-1:0]   s_q, c_q;

        if (k == 0) begin : g_first
            always_comb begin
                a_in        = '0;
                a_in.phase  = ph1_reg;
                a_in.t2     = t2_reg;
                a_in.s_term = T_W'(th1_reg);
                a_in.c_term = T_W'(1) << 30;
                a_in.s_sum  = $signed(S_W'(th1_reg));
                a_in.c_sum  = $signed(S_W'(1) << 30);
            end
            assign vld_in = v1_reg;
        end else begin : g_next
            assign a_in   = st_reg[3*k-1];
            assign vld_in = vld_reg[3*k-1];
        end

        // term times t2
        assign s_p = (2*T_W)'(a_in.s_term) * (2*T_W)'(a_in.t2);
        assign c_p = (2*T_W)'(a_in.c_term) * (2*T_W)'(a_in.t2);
        always_comb begin
            a_nx     = a_in;
            a_nx.s_x = s_p[T_W+29:30];
            a_nx.c_x = c_p[T_W+29:30];
        end

        // quotient estimate by reciprocal, may be one low
        assign s_e = (2*T_W)'(st_reg[3*k].s_x) * (2*T_W)'(S_RECIP);
        assign c_e = (2*T_W)'(st_reg[3*k].c_x) * (2*T_W)'(C_RECIP);
        always_comb begin
            b_nx      = st_reg[3*k];
            b_nx.s_qe = s_e[2*T_W-1:T_W];
            b_nx.c_qe = c_e[2*T_W-1:T_W];
        end

        // correct and accumulate
        assign s_r = (T_W+8)'(st_reg[3*k+1].s_x)
                   - (T_W+8)'(st_reg[3*k+1].s_qe) * (T_W+8)'(SC);
        assign c_r = (T_W+8)'(st_reg[3*k+1].c_x)
                   - (T_W+8)'(st_reg[3*k+1].c_qe) * (T_W+8)'(CC);
        assign s_q = st_reg[3*k+1].s_qe + T_W'(s_r >= (T_W+8)'(SC));
        assign c_q = st_reg[3*k+1].c_qe + T_W'(c_r >= (T_W+8)'(CC));

        always_comb begin
            c_nx        = st_reg[3*k+1];
            c_nx.c_term = c_q;
            c_nx.c_sum  = NEG ? st_reg[3*k+1].c_sum - $signed(S_W'(c_q))
                              : st_reg[3*k+1].c_sum + $signed(S_W'(c_q));
            if (k < SIN_ROUNDS) begin
                c_nx.s_term = s_q;
                c_nx.s_sum  = NEG ? st_reg[3*k+1].s_sum - $signed(S_W'(s_q))
                                  : st_reg[3*k+1].s_sum + $signed(S_W'(s_q));
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[3*k]   <= 1'b0;
                vld_reg[3*k+1] <= 1'b0;
                vld_reg[3*k+2] <= 1'b0;
            end else if (en) begin
                vld_reg[3*k]   <= vld_in;
                vld_reg[3*k+1] <= vld_reg[3*k];
                vld_reg[3*k+2] <= vld_reg[3*k+1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[3*k]   <= a_nx;
                st_reg[3*k+1] <= b_nx;
                st_reg[3*k+2] <= c_nx;
            end
        end
    end

    // round to q15 and fold into the quadrant
    logic [Q15_W-1:0] sv, cv;
    logic [1:0]       quad;
    res_t             res_next;

    assign sv   = to_q15(st_reg[3*ROUNDS-1].s_sum);
    assign cv   = to_q15(st_reg[3*ROUNDS-1].c_sum);
    assign quad = st_reg[3*ROUNDS-1].phase[PH_W-1:PH_W-2];

    always_comb begin
        res_next.phase_turns = st_reg[3*ROUNDS-1].phase;
        unique case (quad)
            2'd0: begin
                res_next.real_part = cv;
                res_next.imag_part = sv;
            end
            2'd1: begin
                res_next.real_part = -sv;
                res_next.imag_part = cv;
            end
            2'd2: begin
                res_next.real_part = -cv;
                res_next.imag_part = -sv;
            end
            default: begin
                res_next.real_part = sv;
                res_next.imag_part = -cv;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = vf_reg;
    assign out_word  = res_reg;

endmodule

`default_nettype wire

### rtl/core/point_source_field_sampler_unit.sv
// point_source_field_sampler_unit: top level, configuration registers,
// pipeline chain and output skid; depends on psfs_pkg and all psfs_ modules
//
//  channel   dir   handshake              word
//  s_axis    in    tvalid/tready          tdata[11:0] sample_index
//  m_axis    out   tvalid/tready          tdata phase_turns, real_part, imag_part
//  cfg       in    cfg_wr_en              cfg_index, cfg_data
//
// one word per cycle while the skid register is empty; the delay from s_axis
// to m_axis is set mostly by the 47 square root stages and the 115 divider stages
// the whole pipeline advances on one enable that drops only while the skid
// register holds a word, so m_axis_tready never reaches s_axis_tready
// reset is synchronous, clears valid bits and loads configuration defaults
`default_nettype none

module point_source_field_sampler_unit
    import psfs_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [15:0]            s_axis_tdata,   // [11:0] sample_index
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [47:0]                 m_axis_tdata,   // phase_turns, real_part, imag_part
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg_reg;
    logic  en;
    logic  g_vld, r_vld, d_vld, t_vld;
    sq_t   g_word;
    rt_t   r_word;
    logic [PH_W-1:0] d_phase;
    res_t  t_word;

    logic  out_vld_reg, skid_vld_reg;
    res_t  out_reg, skid_reg;
    logic  take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wavelength <= WL_W'(100000);
            cfg_reg.distance   <= DIST_W'(64'd1000000000000);
            cfg_reg.aperture   <= LEN_W'(1000000000);
            cfg_reg.spacing    <= LEN_W'(1000000);
            cfg_reg.offset     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WAVELENGTH: cfg_reg.wavelength <= cfg_data[WL_W-1:0];
                REG_DISTANCE:   cfg_reg.distance   <= cfg_data[DIST_W-1:0];
                REG_APERTURE:   cfg_reg.aperture   <= cfg_data[LEN_W-1:0];
                REG_SPACING:    cfg_reg.spacing    <= cfg_data[LEN_W-1:0];
                REG_OFFSET:     cfg_reg.offset     <= $signed(cfg_data[LEN_W-1:0]);
                default: ;
            endcase
        end
    end

    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;

    psfs_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_idx    (s_axis_tdata[IDX_W-1:0]),
        .cfg       (cfg_reg),
        .out_valid (g_vld),
        .out_word  (g_word)
    );

    psfs_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g_vld),
        .in_word   (g_word),
        .distance  (cfg_reg.distance),
        .out_valid (r_vld),
        .out_word  (r_word)
    );

    psfs_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (r_vld),
        .in_word    (r_word),
        .wavelength (cfg_reg.wavelength),
        .out_valid  (d_vld),
        .out_phase  (d_phase)
    );

    psfs_trig u_trig (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_vld),
        .in_phase  (d_phase),
        .out_valid (t_vld),
        .out_word  (t_word)
    );

    assign take = out_vld_reg && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (en && t_vld) begin
            if (!out_vld_reg || take) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (take) begin
            out_vld_reg  <= skid_vld_reg;
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && t_vld) begin
            if (!out_vld_reg || take) begin
                out_reg <= t_word;
            end else begin
                skid_reg <= t_word;
            end
        end else if (take && skid_vld_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

endmodule

`default_nettype wire
